// ===== rtl/core/aip_pkg.sv =====
// shared types, character codes and helpers for the ascii integer parser
package aip_pkg;

   localparam int VALUE_WIDTH = 64;
   localparam int COUNT_WIDTH = 16;
   localparam int DIGIT_WIDTH = 6;
   localparam int BASE_WIDTH  = 6;

   localparam logic [VALUE_WIDTH-1:0] VALUE_TOP  = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
   localparam logic [VALUE_WIDTH-1:0] VALUE_ONES = {VALUE_WIDTH{1'b1}};
   localparam logic [COUNT_WIDTH-1:0] POS_MAX    = {COUNT_WIDTH{1'b1}};

   // configuration register indexes
   localparam logic CSR_NUMBER_BASE = 1'b0;
   localparam logic CSR_SIGNED_MODE = 1'b1;

   localparam logic [BASE_WIDTH-1:0]  BASE_AUTO = 6'd0;
   localparam logic [BASE_WIDTH-1:0]  BASE_ONE  = 6'd1;
   localparam logic [BASE_WIDTH-1:0]  BASE_OCT  = 6'd8;
   localparam logic [BASE_WIDTH-1:0]  BASE_DEC  = 6'd10;
   localparam logic [BASE_WIDTH-1:0]  BASE_HEX  = 6'd16;
   localparam logic [BASE_WIDTH-1:0]  BASE_MAX  = 6'd36;
   localparam logic [DIGIT_WIDTH-1:0] NO_DIGIT  = 6'd36;
   localparam logic [DIGIT_WIDTH-1:0] DIGIT_TEN = 6'd10;

   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_LO_Z  = 8'h7A;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_Z  = 8'h5A;
   localparam logic [7:0] CH_LO_X  = 8'h78;
   localparam logic [7:0] CH_UP_X  = 8'h58;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;

   typedef struct packed {
      logic [7:0] char_code;
      logic       start_flag;
   } req_item_type;

   typedef struct packed {
      logic [63:0] value;
      logic        overflow;
      logic        converted;
      logic [15:0] consumed_count;
   } rsp_item_type;

   // digit value of a character, NO_DIGIT when it is not alphanumeric
   function automatic logic [DIGIT_WIDTH-1:0] digit_of(input logic [7:0] c);
      logic [DIGIT_WIDTH-1:0] d;
      d = NO_DIGIT;
      if (c >= CH_0 && c <= CH_9) begin
         d = DIGIT_WIDTH'(c - CH_0);
      end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
         d = DIGIT_WIDTH'(c - CH_LO_A) + DIGIT_TEN;
      end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
         d = DIGIT_WIDTH'(c - CH_UP_A) + DIGIT_TEN;
      end
      return d;
   endfunction

   // space, tab, line feed, vertical tab, form feed, carriage return
   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
   endfunction

endpackage

// ===== rtl/core/ascii_integer_parser.sv =====
// streaming string to integer converter, one byte per item
//
// Converts a byte stream to a 64-bit integer in the manner of strtol/strtoul.
// A string starts at an item with start_flag set; leading whitespace is
// skipped, an optional sign is taken, the radix comes from number_base (0
// selects hex after 0x/0X followed by a hex digit, octal after a leading 0,
// decimal otherwise) and digits are accumulated until the first byte that
// does not fit. That byte (a NUL included) gives the one result item of the
// string; all other bytes give none. A start flag in the middle of a string
// drops the old string without a result. A radix of 1 or above 36 gives an
// all-zero result at the start byte. Overflow saturates to the signed
// minimum/maximum in signed mode and to all ones in unsigned mode.
// Throughput is one byte per cycle with no gaps while result items are taken and
// no configuration write is offered. An accepted byte is held in the input
// register and worked from there; a result item it gives is offered from the
// result register. While a result item waits on rsp_ready the parse holds,
// the input register fills and req_ready drops until the result is taken.
// The per-byte recurrence is a 64x6 multiply-add of the accumulator by the
// radix plus a compare against the limit, done combinationally.
// Configuration writes are taken when no byte sits in the input register and
// get priority over a byte offered in the same cycle; number_base is latched
// at each start byte, signed_mode applies to every following byte.
module ascii_integer_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  aip_pkg::req_item_type  req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output aip_pkg::rsp_item_type  rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_index,
   input  logic [5:0]             csr_data
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_LEAD,
      PH_FIRST,
      PH_ZERO,
      PH_XPFX,
      PH_DIGITS
   } phase_type;

   // configuration
   logic [aip_pkg::BASE_WIDTH-1:0]  number_base_ff;
   logic                            signed_mode_ff;

   // input and result registers
   logic                            in_vld_ff;
   aip_pkg::req_item_type           in_item_ff;
   logic                            rsp_vld_ff;
   aip_pkg::rsp_item_type           rsp_item_ff;
   aip_pkg::rsp_item_type           rsp_item_in;

   // parse state
   phase_type                        phase_ff, phase_in;
   logic                             neg_ff, neg_in;
   logic [aip_pkg::VALUE_WIDTH-1:0]  acc_ff, acc_in;
   logic                             ovf_ff, ovf_in;
   logic [aip_pkg::BASE_WIDTH-1:0]   base_ff, base_in;
   logic                             seen_ff, seen_in;
   logic [aip_pkg::COUNT_WIDTH-1:0]  pos_ff, pos_in;
   logic [aip_pkg::COUNT_WIDTH-1:0]  zpos_ff, zpos_in;

   // step control
   logic                             fire;
   logic                             emit_hit;
   logic [aip_pkg::COUNT_WIDTH-1:0]  emit_pos;
   logic                             first_hit;
   logic                             add_hit;
   logic [aip_pkg::BASE_WIDTH-1:0]   add_base;
   logic [7:0]                       ch;
   logic [aip_pkg::DIGIT_WIDTH-1:0]  dig;
   logic [aip_pkg::VALUE_WIDTH-1:0]  limit;
   logic [aip_pkg::VALUE_WIDTH+6:0]  product;
   logic [aip_pkg::VALUE_WIDTH-1:0]  result_value;

   // the byte in the input register is worked when the result register can
   // take whatever it may emit
   assign fire      = in_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign csr_ready = !in_vld_ff;
   assign req_ready = (!in_vld_ff || fire) && !csr_valid;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_item_ff;

   assign ch  = in_item_ff.char_code;
   assign dig = aip_pkg::digit_of(ch);

   always_comb begin
      phase_in  = phase_ff;
      neg_in    = neg_ff;
      acc_in    = acc_ff;
      ovf_in    = ovf_ff;
      base_in   = base_ff;
      seen_in   = seen_ff;
      pos_in    = pos_ff;
      zpos_in   = zpos_ff;
      emit_hit  = 1'b0;
      emit_pos  = pos_ff;
      first_hit = 1'b0;
      add_hit   = 1'b0;
      add_base  = base_ff;
      limit     = aip_pkg::VALUE_ONES;
      product   = '0;

      // start byte: fresh string, radix latched from the register
      if (in_item_ff.start_flag) begin
         neg_in  = 1'b0;
         acc_in  = '0;
         ovf_in  = 1'b0;
         seen_in = 1'b0;
         pos_in  = '0;
         zpos_in = '0;
         base_in = number_base_ff;
         if (number_base_ff == aip_pkg::BASE_ONE || number_base_ff > aip_pkg::BASE_MAX) begin
            phase_in = PH_IDLE;
            emit_hit = 1'b1;
            emit_pos = '0;
         end else begin
            phase_in = PH_LEAD;
         end
      end

      if (!emit_hit) begin
         unique case (phase_in)
            PH_LEAD: begin
               if (aip_pkg::is_blank(ch)) begin
                  if (pos_in < aip_pkg::POS_MAX) pos_in = pos_in + 1'b1;
               end else if (ch == aip_pkg::CH_PLUS || ch == aip_pkg::CH_MINUS) begin
                  neg_in   = (ch == aip_pkg::CH_MINUS);
                  if (pos_in < aip_pkg::POS_MAX) pos_in = pos_in + 1'b1;
                  phase_in = PH_FIRST;
               end else begin
                  first_hit = 1'b1;
               end
            end
            PH_FIRST: begin
               first_hit = 1'b1;
            end
            PH_ZERO: begin
               if (ch == aip_pkg::CH_LO_X || ch == aip_pkg::CH_UP_X) begin
                  if (pos_in < aip_pkg::POS_MAX) pos_in = pos_in + 1'b1;
                  phase_in = PH_XPFX;
               end else begin
                  base_in  = (base_in == aip_pkg::BASE_AUTO) ? aip_pkg::BASE_OCT
                                                             : aip_pkg::BASE_HEX;
                  phase_in = PH_DIGITS;
                  if (dig < base_in) begin
                     add_hit = 1'b1;
                  end else begin
                     emit_hit = 1'b1;
                     emit_pos = pos_in;
                  end
               end
            end
            PH_XPFX: begin
               if (dig < aip_pkg::BASE_HEX) begin
                  base_in  = aip_pkg::BASE_HEX;
                  phase_in = PH_DIGITS;
                  add_hit  = 1'b1;
               end else begin
                  // prefix without a hex digit: only the leading zero counts
                  emit_hit = 1'b1;
                  emit_pos = zpos_in;
               end
            end
            PH_DIGITS: begin
               if (base_in >= 6'd2 && base_in <= aip_pkg::BASE_MAX && dig < base_in) begin
                  add_hit = 1'b1;
               end else begin
                  emit_hit = 1'b1;
                  emit_pos = pos_in;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end

      // first character of the number
      if (first_hit) begin
         if (ch == aip_pkg::CH_0 &&
             (base_in == aip_pkg::BASE_AUTO || base_in == aip_pkg::BASE_HEX)) begin
            seen_in  = 1'b1;
            if (pos_in < aip_pkg::POS_MAX) pos_in = pos_in + 1'b1;
            zpos_in  = pos_in;
            phase_in = PH_ZERO;
         end else begin
            if (base_in == aip_pkg::BASE_AUTO) base_in = aip_pkg::BASE_DEC;
            if (dig < base_in) begin
               add_hit  = 1'b1;
               phase_in = PH_DIGITS;
            end else begin
               emit_hit = 1'b1;
               emit_pos = pos_in;
            end
         end
      end

      // accumulate one digit with range check
      add_base = base_in;
      if (signed_mode_ff) begin
         limit = neg_in ? aip_pkg::VALUE_TOP : aip_pkg::VALUE_TOP - 1'b1;
      end
      product = (aip_pkg::VALUE_WIDTH+7)'(acc_in) * (aip_pkg::VALUE_WIDTH+7)'(add_base)
              + (aip_pkg::VALUE_WIDTH+7)'(dig);
      if (add_hit) begin
         if (ovf_in || product > (aip_pkg::VALUE_WIDTH+7)'(limit)) begin
            ovf_in = 1'b1;
         end else begin
            acc_in = product[aip_pkg::VALUE_WIDTH-1:0];
         end
         seen_in = 1'b1;
         if (pos_in < aip_pkg::POS_MAX) pos_in = pos_in + 1'b1;
      end

      if (emit_hit) begin
         phase_in = PH_IDLE;
      end
   end

   // result fields from the state after this byte
   always_comb begin
      result_value = '0;
      if (seen_in) begin
         if (ovf_in) begin
            if (signed_mode_ff) begin
               result_value = neg_in ? aip_pkg::VALUE_TOP : aip_pkg::VALUE_TOP - 1'b1;
            end else begin
               result_value = aip_pkg::VALUE_ONES;
            end
         end else begin
            result_value = neg_in ? (aip_pkg::VALUE_WIDTH'(0) - acc_in) : acc_in;
         end
      end
      rsp_item_in.value          = 64'(result_value);
      rsp_item_in.overflow       = seen_in && ovf_in;
      rsp_item_in.converted      = seen_in;
      rsp_item_in.consumed_count = seen_in ? 16'(emit_pos) : 16'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         number_base_ff <= '0;
         signed_mode_ff <= 1'b1;
         in_vld_ff      <= 1'b0;
         rsp_vld_ff     <= 1'b0;
         phase_ff       <= PH_IDLE;
         neg_ff         <= 1'b0;
         acc_ff         <= '0;
         ovf_ff         <= 1'b0;
         base_ff        <= '0;
         seen_ff        <= 1'b0;
         pos_ff         <= '0;
         zpos_ff        <= '0;
      end else begin
         // configuration write
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               aip_pkg::CSR_NUMBER_BASE: number_base_ff <= csr_data;
               aip_pkg::CSR_SIGNED_MODE: signed_mode_ff <= csr_data[0];
               default: ;
            endcase
         end

         // input register
         if (req_valid && req_ready) begin
            in_vld_ff  <= 1'b1;
            in_item_ff <= req_data;
         end else if (fire) begin
            in_vld_ff <= 1'b0;
         end

         // parse step and result register
         if (fire) begin
            phase_ff <= phase_in;
            neg_ff   <= neg_in;
            acc_ff   <= acc_in;
            ovf_ff   <= ovf_in;
            base_ff  <= base_in;
            seen_ff  <= seen_in;
            pos_ff   <= pos_in;
            zpos_ff  <= zpos_in;
         end
         if (fire && emit_hit) begin
            rsp_vld_ff  <= 1'b1;
            rsp_item_ff <= rsp_item_in;
         end else if (rsp_ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

endmodule

// ===== test/ascii_integer_parser_tb.sv =====
// self-checking testbench for the streaming ascii integer parser
`timescale 1ns / 100ps

module ascii_integer_parser_tb;

   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int DRAIN_CYCLES    = 6;
   localparam int PHASE_COUNT     = 12;
   localparam int BYTES_PER_PHASE = 80;
   localparam int REPORT_LIMIT    = 10;

   // position of the parser inside one string
   typedef enum logic [2:0] {
      PH_IDLE,
      PH_LEAD,
      PH_FIRST,
      PH_ZERO,
      PH_XPFX,
      PH_DIGITS
   } parse_phase_type;

   // tracks the parse of each string and holds the numbers still due out
   class number_parse_tracker_type;
      logic [5:0]            base_reg;
      logic                  signed_reg;
      parse_phase_type       phase;
      logic                  negative;
      logic [63:0]           acc;
      logic                  ovf;
      logic [5:0]            base_now;
      logic                  seen;
      logic [15:0]           pos;
      logic [15:0]           zero_pos;
      aip_pkg::rsp_item_type pending_numbers[$];
      int                    mismatches;

      function new();
         base_reg   = aip_pkg::BASE_AUTO;
         signed_reg = 1'b1;
         phase      = PH_IDLE;
         negative   = 1'b0;
         acc        = '0;
         ovf        = 1'b0;
         base_now   = aip_pkg::BASE_AUTO;
         seen       = 1'b0;
         pos        = '0;
         zero_pos   = '0;
         mismatches = 0;
      endfunction

      function void set_register(logic idx, logic [5:0] data);
         if (idx == aip_pkg::CSR_NUMBER_BASE) begin
            base_reg = data;
         end else begin
            signed_reg = data[0];
         end
      endfunction

      // 0-9 then letters of either case as 10..35
      function logic [5:0] alnum_weight(logic [7:0] c);
         logic [7:0] folded;
         folded = c | 8'h20;
         if (c >= aip_pkg::CH_0 && c <= aip_pkg::CH_9) return 6'(c - aip_pkg::CH_0);
         if (folded >= aip_pkg::CH_LO_A && folded <= aip_pkg::CH_LO_Z) begin
            return 6'(folded - aip_pkg::CH_LO_A) + aip_pkg::DIGIT_TEN;
         end
         return aip_pkg::NO_DIGIT;
      endfunction

      function bit is_space_char(logic [7:0] c);
         case (c)
            8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D: return 1'b1;
            default: return 1'b0;
         endcase
      endfunction

      function void step_position();
         if (pos < aip_pkg::POS_MAX) pos++;
      endfunction

      function void accumulate(logic [5:0] d, logic [5:0] b);
         logic [63:0] limit;
         logic [63:0] cutoff;
         logic [63:0] cutlim;
         logic [63:0] b64;
         b64 = 64'(b);
         if (signed_reg) begin
            limit = negative ? aip_pkg::VALUE_TOP : aip_pkg::VALUE_TOP - 64'd1;
         end else begin
            limit = aip_pkg::VALUE_ONES;
         end
         cutoff = limit / b64;
         cutlim = limit % b64;
         if (ovf || acc > cutoff || (acc == cutoff && 64'(d) > cutlim)) begin
            ovf = 1'b1;
         end else begin
            acc = acc * b64 + 64'(d);
         end
         seen = 1'b1;
         step_position();
      endfunction

      function void finish_number(logic [15:0] count);
         aip_pkg::rsp_item_type num;
         logic [63:0]           v;
         v = '0;
         if (seen) begin
            if (ovf) begin
               v = signed_reg ? (negative ? aip_pkg::VALUE_TOP : aip_pkg::VALUE_TOP - 64'd1)
                              : aip_pkg::VALUE_ONES;
            end else begin
               v = negative ? -acc : acc;
            end
         end
         num.value          = v;
         num.overflow       = seen && ovf;
         num.converted      = seen;
         num.consumed_count = seen ? count : 16'd0;
         pending_numbers.push_back(num);
         phase = PH_IDLE;
      endfunction

      // returns 0 when the byte is dropped by an idle parser
      function bit take_byte(aip_pkg::req_item_type r);
         logic [7:0] c;
         logic [5:0] d;
         c = r.char_code;
         d = alnum_weight(c);
         if (r.start_flag) begin
            negative = 1'b0;
            acc      = '0;
            ovf      = 1'b0;
            seen     = 1'b0;
            pos      = '0;
            zero_pos = '0;
            base_now = base_reg;
            if (base_now == aip_pkg::BASE_ONE || base_now > aip_pkg::BASE_MAX) begin
               finish_number(16'd0);
               return 1'b1;
            end
            phase = PH_LEAD;
         end
         if (phase == PH_IDLE) return 1'b0;
         if (phase == PH_LEAD) begin
            if (is_space_char(c)) begin
               step_position();
               return 1'b1;
            end
            if (c == aip_pkg::CH_PLUS || c == aip_pkg::CH_MINUS) begin
               negative = (c == aip_pkg::CH_MINUS);
               step_position();
               phase = PH_FIRST;
               return 1'b1;
            end
            phase = PH_FIRST;
         end
         case (phase)
            PH_FIRST: begin
               if (c == aip_pkg::CH_0 &&
                   (base_now == aip_pkg::BASE_AUTO || base_now == aip_pkg::BASE_HEX)) begin
                  seen = 1'b1;
                  step_position();
                  zero_pos = pos;
                  phase = PH_ZERO;
                  return 1'b1;
               end
               if (base_now == aip_pkg::BASE_AUTO) base_now = aip_pkg::BASE_DEC;
               if (d < base_now) begin
                  accumulate(d, base_now);
                  phase = PH_DIGITS;
               end else begin
                  finish_number(pos);
               end
            end
            PH_ZERO: begin
               if (c == aip_pkg::CH_LO_X || c == aip_pkg::CH_UP_X) begin
                  step_position();
                  phase = PH_XPFX;
                  return 1'b1;
               end
               base_now = (base_now == aip_pkg::BASE_AUTO) ? aip_pkg::BASE_OCT
                                                           : aip_pkg::BASE_HEX;
               phase = PH_DIGITS;
               if (d < base_now) accumulate(d, base_now);
               else finish_number(pos);
            end
            PH_XPFX: begin
               if (d < aip_pkg::BASE_HEX) begin
                  base_now = aip_pkg::BASE_HEX;
                  phase = PH_DIGITS;
                  accumulate(d, aip_pkg::BASE_HEX);
               end else begin
                  finish_number(zero_pos);
               end
            end
            PH_DIGITS: begin
               if (base_now >= 6'd2 && base_now <= aip_pkg::BASE_MAX && d < base_now) begin
                  accumulate(d, base_now);
               end else begin
                  finish_number(pos);
               end
            end
            default: phase = PH_IDLE;
         endcase
         return 1'b1;
      endfunction

      function void compare_result(aip_pkg::rsp_item_type got);
         aip_pkg::rsp_item_type want;
         if (pending_numbers.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("unexpected result item: value %h overflow %b converted %b count %0d",
                        got.value, got.overflow, got.converted, got.consumed_count);
            end
            return;
         end
         want = pending_numbers.pop_front();
         if (got.value !== want.value || got.overflow !== want.overflow ||
             got.converted !== want.converted || got.consumed_count !== want.consumed_count) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("result mismatch: value exp %h got %h", want.value, got.value);
               $display("   overflow exp %b got %b, converted exp %b got %b",
                        want.overflow, got.overflow, want.converted, got.converted);
               $display("   count exp %0d got %0d", want.consumed_count, got.consumed_count);
            end
         end
      endfunction

      function int outstanding();
         return pending_numbers.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   aip_pkg::req_item_type req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   aip_pkg::rsp_item_type rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic                  csr_index;
   logic [5:0]            csr_data;

   number_parse_tracker_type tracker = new();

   int  idle_pct;
   int  stall_pct;
   int  bytes_taken;
   int  cycle_count;
   bit  fresh_string;

   // phase table: radix and signedness for each random phase
   logic [5:0] phase_base [PHASE_COUNT] = '{aip_pkg::BASE_AUTO, aip_pkg::BASE_MAX, 6'd2,
                                            aip_pkg::BASE_DEC, aip_pkg::BASE_HEX,
                                            aip_pkg::BASE_OCT, aip_pkg::BASE_AUTO,
                                            aip_pkg::BASE_ONE, 6'd63, 6'd3,
                                            aip_pkg::BASE_MAX, aip_pkg::BASE_HEX};
   bit         phase_signed [PHASE_COUNT] = '{1, 0, 1, 0, 1, 0, 0, 1, 0, 1, 1, 0};
   int         idle_table [4]  = '{0, 52, 0, 28};
   int         stall_table [4] = '{0, 0, 52, 28};
   logic [7:0] blank_chars [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
   logic [7:0] stop_chars [6]  = '{8'h2E, 8'h2C, 8'h20, 8'h5F, 8'h3B, 8'h7F};
   // digit runs at and just past the signed and unsigned overflow limits
   string      dec_limits [4]  = '{"9223372036854775807", "9223372036854775808",
                                   "18446744073709551615", "18446744073709551616"};
   string      hex_limits [4]  = '{"7fffffffffffffff", "8000000000000000",
                                   "FFFFFFFFFFFFFFFF", "10000000000000000"};

   ascii_integer_parser i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #10 clock = ~clock;

   // watchdog on total run length
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // result side: random back-pressure, changed on the falling edge only
   always @(negedge clock) begin
      rsp_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
   end

   // every accepted result item is checked against the oldest expected number
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) tracker.compare_result(rsp_data);
   end

   // one byte item; entered and left on a falling edge
   task automatic send_byte(input logic [7:0] c, input logic s);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{char_code: c, start_flag: s};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (tracker.take_byte(req_data)) bytes_taken++;
      @(negedge clock);
   endtask

   // next byte of the current string, start flag on its first byte
   task automatic push_char(input logic [7:0] c);
      send_byte(c, fresh_string);
      fresh_string = 1'b0;
   endtask

   // let every expected number come out, then cover the pipeline latency
   task automatic drain_and_pause();
      req_valid <= 1'b0;
      while (tracker.outstanding() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // register write; only called with the parser drained
   task automatic write_csr(input logic idx, input logic [5:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tracker.set_register(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [7:0] digit_char(int v);
      if (v < 10) return aip_pkg::CH_0 + 8'(v);
      return ($urandom_range(1) ? aip_pkg::CH_LO_A : aip_pkg::CH_UP_A) + 8'(v - 10);
   endfunction

   // mostly well-formed numbers with random content, some noise
   task automatic send_random_string();
      int         roll;
      int         eb;
      int         digits;
      logic [5:0] b;
      string      run;
      b = tracker.base_reg;
      roll = $urandom_range(99);
      if (roll < 8) begin
         // noise with occasional restarts
         send_byte(8'($urandom_range(255)), 1'b1);
         repeat ($urandom_range(5)) send_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
         return;
      end
      fresh_string = 1'b1;
      if ($urandom_range(3) == 0) begin
         repeat ($urandom_range(1, 3)) push_char(blank_chars[$urandom_range(5)]);
      end
      case ($urandom_range(3))
         0: push_char(aip_pkg::CH_PLUS);
         1: push_char(aip_pkg::CH_MINUS);
         default: ;
      endcase
      eb = (b == aip_pkg::BASE_ONE || b > aip_pkg::BASE_MAX) ? 10 : int'(b);
      if (b == aip_pkg::BASE_AUTO || b == aip_pkg::BASE_HEX) begin
         case ($urandom_range(3))
            0: begin
               push_char(aip_pkg::CH_0);
               push_char(aip_pkg::CH_LO_X);
               eb = 16;
            end
            1: begin
               push_char(aip_pkg::CH_0);
               push_char(aip_pkg::CH_UP_X);
               eb = 16;
            end
            2: begin
               if (b == aip_pkg::BASE_AUTO) begin
                  push_char(aip_pkg::CH_0);
                  eb = 8;
               end
            end
            default: ;
         endcase
      end
      if (eb == 0) eb = 10;
      if ((eb == 10 || eb == 16) && $urandom_range(99) < 10) begin
         // near the overflow cutoff, optionally one digit further
         run = (eb == 10) ? dec_limits[$urandom_range(3)] : hex_limits[$urandom_range(3)];
         for (int k = 0; k < run.len(); k++) push_char(run[k]);
         if ($urandom_range(1)) push_char(digit_char($urandom_range(eb - 1)));
      end else begin
         digits = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, eb <= 4 ? 70 : 24);
         repeat (digits) begin
            if ($urandom_range(39) == 0) push_char(8'($urandom_range(255)));
            else push_char(digit_char($urandom_range(eb - 1)));
         end
      end
      // terminator: nul, any byte, punctuation, or none so the next start cuts in
      roll = $urandom_range(99);
      if (roll < 40) push_char(8'h00);
      else if (roll < 65) push_char(8'($urandom_range(255)));
      else if (roll < 85) push_char(stop_chars[$urandom_range(5)]);
      // stray bytes without a start flag
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)), 1'b0);
      end
   endtask

   initial begin
      int target;
      clock        = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      rsp_ready    = 1'b0;
      csr_valid    = 1'b0;
      csr_index    = aip_pkg::CSR_NUMBER_BASE;
      csr_data     = '0;
      idle_pct     = 0;
      stall_pct    = 0;
      bytes_taken  = 0;
      cycle_count  = 0;
      fresh_string = 1'b0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part, reset settings: auto radix, signed
      send_byte(aip_pkg::CH_UP_A, 1'b0);     // idle byte without start, dropped
      fresh_string = 1'b1;                   // negative hex with blank and prefix
      push_char(aip_pkg::CH_SPACE);
      push_char(aip_pkg::CH_MINUS);
      push_char(aip_pkg::CH_0);
      push_char(aip_pkg::CH_LO_X);
      push_char(8'h31);
      push_char(8'h46);
      push_char(8'h00);
      fresh_string = 1'b1;                   // prefix with no hex digit after it
      push_char(aip_pkg::CH_0);
      push_char(aip_pkg::CH_UP_X);
      push_char(8'h67);
      fresh_string = 1'b1;                   // octal, ended by the top byte value
      push_char(aip_pkg::CH_0);
      push_char(8'h31);
      push_char(8'h37);
      push_char(8'hFF);
      fresh_string = 1'b1;                   // restart in the middle of a string
      push_char(8'h31);
      push_char(8'h32);
      fresh_string = 1'b1;
      push_char(8'h37);
      push_char(8'h00);

      // radix out of range answers at the start byte
      drain_and_pause();
      write_csr(aip_pkg::CSR_NUMBER_BASE, 6'd37);
      fresh_string = 1'b1;
      push_char(aip_pkg::CH_UP_Z);

      // signedness switched while a string is open
      drain_and_pause();
      write_csr(aip_pkg::CSR_NUMBER_BASE, aip_pkg::BASE_DEC);
      fresh_string = 1'b1;
      push_char(aip_pkg::CH_MINUS);
      push_char(8'h35);
      drain_and_pause();
      write_csr(aip_pkg::CSR_SIGNED_MODE, 6'd0);
      push_char(8'h00);

      // random phases, each with its own settings and idling pattern
      for (int p = 0; p < PHASE_COUNT; p++) begin
         drain_and_pause();
         write_csr(aip_pkg::CSR_NUMBER_BASE, phase_base[p]);
         write_csr(aip_pkg::CSR_SIGNED_MODE, {5'($urandom_range(31)), phase_signed[p]});
         idle_pct  = idle_table[p % 4];
         stall_pct = stall_table[p % 4];
         target = bytes_taken + BYTES_PER_PHASE;
         while (bytes_taken < target) send_random_string();
      end

      drain_and_pause();
      if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== ascii_integer_parser.f =====
rtl/core/aip_pkg.sv
rtl/core/ascii_integer_parser.sv
test/ascii_integer_parser_tb.sv
